>>> rtl/rns_pkg.sv
package rns_pkg;

  localparam int unsigned RNS_MAX_MODULI = 6;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned MOD_W          = 61;
  localparam int unsigned COUNT_W        = 3;
  localparam int unsigned TOTAL_W        = 9;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned MOD_IDX_W      = 3;
  localparam int unsigned STEP_W         = 7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT = 3'd0,
    REG_MOD0  = 3'd1,
    REG_MOD1  = 3'd2,
    REG_MOD2  = 3'd3,
    REG_MOD3  = 3'd4,
    REG_MOD4  = 3'd5,
    REG_MOD5  = 3'd6,
    REG_TOTAL = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ERR,
    S_DIV,
    S_FIX
  } rns_state_e;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic step;
    logic load_res;
    logic load_err;
    logic next_mod;
  } rns_cmd_t;

  typedef struct packed {
    logic size_ok;
    logic div_done;
    logic last_mod;
  } rns_sts_t;

endpackage

>>> rtl/rns_ctrl.sv
module rns_ctrl
  import rns_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rns_sts_t sts_i,
  output rns_cmd_t cmd_o
);

  rns_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: state_d = sts_i.size_ok ? S_DIV : S_ERR;
      S_ERR:   if (slot_free) state_d = S_IDLE;
      S_DIV:   if (sts_i.div_done) state_d = S_FIX;
      S_FIX: begin
        if (slot_free) state_d = sts_i.last_mod ? S_IDLE : S_DIV;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.load_in = in_valid_i;
      S_CHECK: cmd_o.start_div = sts_i.size_ok;
      S_ERR:   cmd_o.load_err = slot_free;
      S_DIV:   cmd_o.step = !sts_i.div_done;
      S_FIX: begin
        cmd_o.load_res  = slot_free;
        cmd_o.next_mod  = slot_free && !sts_i.last_mod;
        cmd_o.start_div = slot_free && !sts_i.last_mod;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_res || cmd_o.load_err) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/rns_datapath.sv
module rns_datapath
  import rns_pkg::*;
#(
  parameter int unsigned MAX_MODULI = RNS_MAX_MODULI
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MOD_W-1:0]     cfg_wdata_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  rns_cmd_t             cmd_i,
  output rns_sts_t             sts_o,
  output logic [MOD_W-1:0]     residue_o,
  output logic [MOD_IDX_W-1:0] modulus_index_o,
  output logic                 last_o,
  output logic                 too_large_o
);

  localparam int unsigned IdxW = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;

  // configuration
  logic [COUNT_W-1:0] count_q;
  logic [TOTAL_W-1:0] total_q;
  logic [MOD_W-1:0]   mod_q [MAX_MODULI];
  logic [CFG_IDX_W-1:0] mod_sel;

  assign mod_sel = cfg_index_i - REG_MOD0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
      total_q <= '0;
      for (int i = 0; i < MAX_MODULI; i++) mod_q[i] <= MOD_W'(2);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_COUNT) begin
        count_q <= cfg_wdata_i[COUNT_W-1:0];
      end else if (cfg_index_i == REG_TOTAL) begin
        total_q <= cfg_wdata_i[TOTAL_W-1:0];
      end else if (mod_sel < CFG_IDX_W'(MAX_MODULI)) begin
        mod_q[mod_sel[IdxW-1:0]] <= cfg_wdata_i;
      end
    end
  end

  // operand and divider state
  logic               neg_q;
  logic [VALUE_W-1:0] mag_q, dvd_q;
  logic [MOD_W-1:0]   rem_q;
  logic [STEP_W-1:0]  step_q;
  logic [IdxW-1:0]    idx_q;
  logic [MOD_W-1:0]   q;
  logic [MOD_W:0]     trial;
  logic               fits;

  assign q     = mod_q[idx_q];
  assign trial = {rem_q, dvd_q[VALUE_W-1]};
  assign fits  = trial >= {1'b0, q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      step_q <= '0;
    end else begin
      if (cmd_i.load_in) idx_q <= '0;
      else if (cmd_i.next_mod) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.start_div) step_q <= '0;
      else if (cmd_i.step) step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      neg_q <= value_i[VALUE_W-1];
      mag_q <= value_i[VALUE_W-1] ? (~value_i + VALUE_W'(1)) : value_i;
    end
    if (cmd_i.start_div) begin
      rem_q <= '0;
      dvd_q <= mag_q;
    end else if (cmd_i.step) begin
      rem_q <= fits ? MOD_W'(trial - {1'b0, q}) : trial[MOD_W-1:0];
      dvd_q <= {dvd_q[VALUE_W-2:0], 1'b0};
    end
  end

  // size check: significant bits + 2 < total  <=>  mag < 2^(total-3)
  logic [TOTAL_W-1:0] shamt;
  logic               size_ok;

  assign shamt = total_q - TOTAL_W'(3);

  always_comb begin
    if (total_q < TOTAL_W'(3)) size_ok = 1'b0;
    else if (shamt >= TOTAL_W'(VALUE_W)) size_ok = 1'b1;
    else size_ok = (mag_q >> shamt[5:0]) == '0;
  end

  // active modulus count, zero acting as one and saturating at the limit
  logic [COUNT_W-1:0] n_eff;

  always_comb begin
    priority if (count_q == '0) n_eff = COUNT_W'(1);
    else if (count_q > COUNT_W'(MAX_MODULI)) n_eff = COUNT_W'(MAX_MODULI);
    else n_eff = count_q;
  end

  assign sts_o.size_ok  = size_ok;
  assign sts_o.div_done = step_q[STEP_W-1];
  assign sts_o.last_mod = (COUNT_W'(idx_q) == n_eff - COUNT_W'(1));

  logic [MOD_W-1:0] res_final;

  always_comb begin
    if (q == '0) res_final = '0;
    else if (neg_q && rem_q != '0) res_final = q - rem_q;
    else res_final = rem_q;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      residue_o       <= res_final;
      modulus_index_o <= MOD_IDX_W'(idx_q);
      last_o          <= sts_o.last_mod;
      too_large_o     <= 1'b0;
    end else if (cmd_i.load_err) begin
      residue_o       <= '0;
      modulus_index_o <= '0;
      last_o          <= 1'b1;
      too_large_o     <= 1'b1;
    end
  end

endmodule

>>> rtl/signed_int_to_rns_residues.sv
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o  value_i
// out       output     out_valid_o/out_ready_i residue_o, modulus_index_o, last_o, too_large_o
// cfg       input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// each residue is a 64-step restoring division, one quotient bit per cycle,
// after which S_DIV sees it finish and S_FIX folds in the sign and loads the
// result register.
// the next division runs while a result waits; a stalled output blocks only
// the loading of the following result. reset is asynchronous, active low, and
// restores the register defaults.
module signed_int_to_rns_residues
  import rns_pkg::*;
#(
  parameter int unsigned MAX_MODULI = RNS_MAX_MODULI
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MOD_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MOD_W-1:0]     residue_o,
  output logic [MOD_IDX_W-1:0] modulus_index_o,
  output logic                 last_o,
  output logic                 too_large_o
);

  rns_cmd_t cmd;
  rns_sts_t sts;

  rns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rns_datapath #(
    .MAX_MODULI (MAX_MODULI)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .residue_o       (residue_o),
    .modulus_index_o (modulus_index_o),
    .last_o          (last_o),
    .too_large_o     (too_large_o)
  );

  // an error result stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_large_o |-> last_o && residue_o == '0 && modulus_index_o == '0)
    else $error("error result malformed");

  // more residues of the same transaction are still to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input taken before all residues were produced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !too_large_o |-> modulus_index_o < MOD_IDX_W'(MAX_MODULI))
    else $error("modulus index out of range");

endmodule
